// File: design/bmc_pkg.sv
// ----------------------------------------------------------------------------
// bmc_pkg : shared types and codes for the backtracking maze carver
// Direction codes, carving phases and the packed cell word kept in memory.
// ----------------------------------------------------------------------------
package bmc_pkg;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic ACT_START = 1'b0;

    localparam logic SIDE_UPPER = 1'b0;
    localparam logic SIDE_LEFT  = 1'b1;

    localparam logic KIND_CARVE = 1'b0;
    localparam logic KIND_OPEN  = 1'b1;

    typedef enum logic [1:0] {
        PH_CHECK = 2'd0,
        PH_CARVE = 2'd1,
        PH_FINAL = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    typedef struct packed {
        logic vis;
        logic up;
        logic left;
    } cell_word_t;

    localparam int CELL_WORD_W = $bits(cell_word_t);

endpackage

// File: design/bmc_ram.sv
// ----------------------------------------------------------------------------
// bmc_ram : single write port, single read port synchronous RAM
// Read data is registered and appears in the cycle after the read request.
// ----------------------------------------------------------------------------
module bmc_ram #(
    parameter int DATA_W = 3,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/backtracking_maze_carver_top.sv
// ----------------------------------------------------------------------------
// backtracking_maze_carver_top : randomized depth-first maze carver
// Sequencer around a cell memory (visited and wall bits) and a link memory.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one beat is a command. action 0 starts
// a new maze, action 1 supplies one 2-bit direction draw. Output channel
// (out_valid / out_stall): one beat per cleared wall, zero or one per draw,
// the last wall of the maze flagged by maze_done. cfg_we / cfg_wdata set the
// dead-end opening enable; write only while the block is idle.
// A draw reads the current cell and its four neighbors through the single
// cell-memory read port, then decides. Each backtrack step adds one link-memory
// read plus a new 5-cell gather. A carve or opening writes 1 or 2 words, then
// the result is loaded into the output register; after the last carve the
// final cell is gathered and checked before the result is loaded. One draw is
// in flight at a time.
// Reset and a start command both run a clearing pass over the cell memory,
// one write per cell for all GRID_WIDTH*GRID_HEIGHT cells; in_stall is high
// during it. If the receiver stalls, the finished beat waits in the output
// register and the sequencer holds before loading the next one.
// ----------------------------------------------------------------------------
module backtracking_maze_carver_top
    import bmc_pkg::*;
#(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [1:0] direction_draw,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] wall_cell_x,
    output logic [3:0] wall_cell_y,
    output logic       wall_side,
    output logic       opening_kind,
    output logic       maze_done
);

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int TOTAL = (GRID_WIDTH - 2) * (GRID_HEIGHT - 2);
    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(TOTAL + 1);
    localparam int BW    = $clog2(CELLS + 1);
    localparam int LW    = XW + YW;

    localparam logic [XW-1:0] X_ONE  = XW'(1);
    localparam logic [YW-1:0] Y_ONE  = YW'(1);
    localparam logic [XW-1:0] X_LAST = XW'(GRID_WIDTH - 1);
    localparam logic [YW-1:0] Y_LAST = YW'(GRID_HEIGHT - 1);
    localparam logic [XW-1:0] X_EDGE = XW'(GRID_WIDTH - 2);
    localparam logic [YW-1:0] Y_EDGE = YW'(GRID_HEIGHT - 2);

    // gather slots: center, then neighbor in direction code order
    localparam logic [2:0] SLOT_C = 3'd0;
    localparam logic [2:0] SLOT_U = 3'd1;
    localparam logic [2:0] SLOT_D = 3'd2;
    localparam logic [2:0] SLOT_L = 3'd3;
    localparam logic [2:0] SLOT_R = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_WAIT,
        S_DECIDE,
        S_LINKW,
        S_WR1,
        S_WR2,
        S_EMIT
    } state_t;

    function automatic logic [AW-1:0] cell_idx(input logic [XW-1:0] x,
                                               input logic [YW-1:0] y);
        return AW'(AW'(y) * AW'(GRID_WIDTH)) + AW'(x);
    endfunction

    state_t            state_reg;
    phase_t            phase_reg;
    logic              ode_reg;
    logic [XW-1:0]     cur_x_reg;
    logic [YW-1:0]     cur_y_reg;
    logic [CW-1:0]     cnt_reg;
    logic [BW-1:0]     bt_cnt_reg;
    logic [1:0]        dir_reg;
    logic [2:0]        rd_k_reg;
    logic              rvalid_reg;
    logic [2:0]        rslot_reg;
    cell_word_t        nb_reg [5];
    logic              post_carve_reg;
    logic [XW-1:0]     clr_x_reg;
    logic [YW-1:0]     clr_y_reg;

    logic              carve_reg;
    logic              wr2_en_reg;
    logic [AW-1:0]     wr1_addr_reg;
    cell_word_t        wr1_data_reg;
    logic [AW-1:0]     wr2_addr_reg;
    cell_word_t        wr2_data_reg;
    logic [XW-1:0]     n_x_reg;
    logic [YW-1:0]     n_y_reg;
    logic [XW-1:0]     wx_reg;
    logic [YW-1:0]     wy_reg;
    logic              side_reg;
    logic              kind_reg;
    logic              done_reg;

    logic              out_valid_reg;
    logic [3:0]        out_x_reg;
    logic [3:0]        out_y_reg;
    logic              out_side_reg;
    logic              out_kind_reg;
    logic              out_done_reg;

    // memory ports
    logic              cell_we;
    logic [AW-1:0]     cell_waddr;
    cell_word_t        cell_wdata;
    logic              cell_re;
    logic [AW-1:0]     cell_raddr;
    logic [CELL_WORD_W-1:0] cell_rdata;
    logic              link_we;
    logic              link_re;
    logic [LW-1:0]     link_rdata;

    // decision terms
    logic [XW-1:0]     rd_x;
    logic [YW-1:0]     rd_y;
    logic              dead;
    logic [3:0]        tgt_ok;
    logic              can_open;
    logic              need_open;
    logic [2:0]        n_slot;
    logic [XW-1:0]     nx;
    logic [YW-1:0]     ny;
    logic [XW-1:0]     wx;
    logic [YW-1:0]     wy;
    logic              side;
    logic [AW-1:0]     open_addr;
    cell_word_t        open_data;
    logic [AW-1:0]     c1_addr;
    cell_word_t        c1_data;
    logic [AW-1:0]     c2_addr;
    cell_word_t        c2_data;
    logic              c2_en;
    cell_word_t        clr_word;
    logic [CW-1:0]     cnt_inc;
    logic              out_free;
    logic              clr_border;

    bmc_ram #(
        .DATA_W (CELL_WORD_W),
        .ADDR_W (AW)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .re    (cell_re),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    bmc_ram #(
        .DATA_W (LW),
        .ADDR_W (AW)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (cell_idx(n_x_reg, n_y_reg)),
        .wdata ({cur_y_reg, cur_x_reg}),
        .re    (link_re),
        .raddr (cell_idx(cur_x_reg, cur_y_reg)),
        .rdata (link_rdata)
    );

    always_comb
    begin
        rd_x = cur_x_reg;
        rd_y = cur_y_reg;
        case (rd_k_reg)
            SLOT_U:  rd_y = cur_y_reg - Y_ONE;
            SLOT_D:  rd_y = cur_y_reg + Y_ONE;
            SLOT_L:  rd_x = cur_x_reg - X_ONE;
            SLOT_R:  rd_x = cur_x_reg + X_ONE;
            default: ;
        endcase
    end

    always_comb
    begin
        clr_border = (clr_x_reg == '0) || (clr_x_reg == X_LAST) ||
                     (clr_y_reg == '0) || (clr_y_reg == Y_LAST);
        clr_word.vis  = clr_border || (clr_x_reg == X_ONE && clr_y_reg == Y_ONE);
        clr_word.up   = !((clr_x_reg == '0) || (clr_x_reg == X_LAST) ||
                          (clr_y_reg == '0));
        clr_word.left = !((clr_x_reg == '0) || (clr_y_reg == '0) ||
                          (clr_y_reg == Y_LAST));
    end

    always_comb
    begin
        dead = nb_reg[SLOT_U].vis && nb_reg[SLOT_D].vis &&
               nb_reg[SLOT_L].vis && nb_reg[SLOT_R].vis;
        tgt_ok[DIR_UP]    = nb_reg[SLOT_C].up   && (cur_y_reg != Y_ONE);
        tgt_ok[DIR_DOWN]  = nb_reg[SLOT_D].up   && (cur_y_reg != Y_EDGE);
        tgt_ok[DIR_LEFT]  = nb_reg[SLOT_C].left && (cur_x_reg != X_ONE);
        tgt_ok[DIR_RIGHT] = nb_reg[SLOT_R].left && (cur_x_reg != X_EDGE);
        can_open  = |tgt_ok;
        need_open = ode_reg && dead && can_open;
        n_slot    = {1'b0, dir_reg} + 3'd1;

        nx      = cur_x_reg;
        ny      = cur_y_reg;
        wx      = cur_x_reg;
        wy      = cur_y_reg;
        side    = SIDE_UPPER;
        open_addr = cell_idx(cur_x_reg, cur_y_reg);
        open_data = nb_reg[SLOT_C];
        c1_addr = cell_idx(cur_x_reg, cur_y_reg);
        c1_data = nb_reg[SLOT_C];
        c2_data = nb_reg[SLOT_C];
        c2_en   = 1'b0;
        case (dir_reg)
            DIR_UP:
            begin
                ny = cur_y_reg - Y_ONE;
                open_data.up = 1'b0;
                c1_data.up   = 1'b0;
                c2_data      = nb_reg[SLOT_U];
                c2_data.vis  = 1'b1;
                c2_en        = 1'b1;
            end
            DIR_DOWN:
            begin
                ny = cur_y_reg + Y_ONE;
                wy = cur_y_reg + Y_ONE;
                open_addr    = cell_idx(cur_x_reg, cur_y_reg + Y_ONE);
                open_data    = nb_reg[SLOT_D];
                open_data.up = 1'b0;
                c1_addr      = open_addr;
                c1_data      = open_data;
                c1_data.vis  = 1'b1;
            end
            DIR_LEFT:
            begin
                nx   = cur_x_reg - X_ONE;
                side = SIDE_LEFT;
                open_data.left = 1'b0;
                c1_data.left   = 1'b0;
                c2_data        = nb_reg[SLOT_L];
                c2_data.vis    = 1'b1;
                c2_en          = 1'b1;
            end
            default:
            begin
                nx   = cur_x_reg + X_ONE;
                wx   = cur_x_reg + X_ONE;
                side = SIDE_LEFT;
                open_addr      = cell_idx(cur_x_reg + X_ONE, cur_y_reg);
                open_data      = nb_reg[SLOT_R];
                open_data.left = 1'b0;
                c1_addr        = open_addr;
                c1_data        = open_data;
                c1_data.vis    = 1'b1;
            end
        endcase
        c2_addr = cell_idx(nx, ny);
        cnt_inc = cnt_reg + CW'(1);
        out_free = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        cell_we    = 1'b0;
        cell_waddr = wr1_addr_reg;
        cell_wdata = wr1_data_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = cell_idx(clr_x_reg, clr_y_reg);
                cell_wdata = clr_word;
            end
            S_WR1:
            begin
                cell_we = 1'b1;
            end
            S_WR2:
            begin
                cell_we    = 1'b1;
                cell_waddr = wr2_addr_reg;
                cell_wdata = wr2_data_reg;
            end
            default: ;
        endcase
        cell_re    = (state_reg == S_RD);
        cell_raddr = cell_idx(rd_x, rd_y);
        link_we    = (state_reg == S_WR1) && carve_reg;
        link_re    = (state_reg == S_DECIDE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            phase_reg      <= PH_CHECK;
            ode_reg        <= 1'b1;
            cur_x_reg      <= X_ONE;
            cur_y_reg      <= Y_ONE;
            cnt_reg        <= CW'(1);
            bt_cnt_reg     <= '0;
            rd_k_reg       <= '0;
            rvalid_reg     <= 1'b0;
            rslot_reg      <= '0;
            post_carve_reg <= 1'b0;
            clr_x_reg      <= '0;
            clr_y_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ode_reg <= cfg_wdata;
            end
            if (out_valid_reg && !out_stall && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            rvalid_reg <= (state_reg == S_RD);
            rslot_reg  <= rd_k_reg;
            if (rvalid_reg)
            begin
                nb_reg[rslot_reg] <= cell_word_t'(cell_rdata);
            end

            case (state_reg)
                S_CLEAR:
                begin
                    if (clr_x_reg == X_LAST)
                    begin
                        clr_x_reg <= '0;
                        if (clr_y_reg == Y_LAST)
                        begin
                            clr_y_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            clr_y_reg <= clr_y_reg + Y_ONE;
                        end
                    end
                    else
                    begin
                        clr_x_reg <= clr_x_reg + X_ONE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (action == ACT_START)
                        begin
                            cur_x_reg      <= X_ONE;
                            cur_y_reg      <= Y_ONE;
                            cnt_reg        <= CW'(1);
                            phase_reg      <= PH_CHECK;
                            post_carve_reg <= 1'b0;
                            state_reg      <= S_CLEAR;
                        end
                        else if (phase_reg != PH_DONE)
                        begin
                            dir_reg    <= direction_draw;
                            bt_cnt_reg <= '0;
                            rd_k_reg   <= '0;
                            state_reg  <= S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    if (rd_k_reg == SLOT_R)
                    begin
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        rd_k_reg <= rd_k_reg + 3'd1;
                    end
                end
                S_WAIT:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    rd_k_reg <= '0;
                    if (post_carve_reg)
                    begin
                        // last carve: check the final cell for a dead end
                        post_carve_reg <= 1'b0;
                        done_reg  <= !need_open;
                        phase_reg <= need_open ? PH_FINAL : PH_DONE;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        wx_reg   <= wx;
                        wy_reg   <= wy;
                        side_reg <= side;
                        n_x_reg  <= nx;
                        n_y_reg  <= ny;
                        // dead-end opening is only tried at the cell the draw started on
                        if ((phase_reg == PH_FINAL) ||
                            ((phase_reg == PH_CHECK) && need_open && (bt_cnt_reg == '0)))
                        begin
                            if (phase_reg == PH_FINAL && !can_open)
                            begin
                                phase_reg <= PH_DONE;
                                state_reg <= S_IDLE;
                            end
                            else if (tgt_ok[dir_reg])
                            begin
                                carve_reg    <= 1'b0;
                                wr2_en_reg   <= 1'b0;
                                wr1_addr_reg <= open_addr;
                                wr1_data_reg <= open_data;
                                kind_reg     <= KIND_OPEN;
                                done_reg     <= (phase_reg == PH_FINAL);
                                phase_reg    <= (phase_reg == PH_FINAL) ? PH_DONE : PH_CARVE;
                                state_reg    <= S_WR1;
                            end
                            else
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                        else if (dead)
                        begin
                            // backtrack one link; the link read is issued this cycle
                            if (bt_cnt_reg != BW'(CELLS))
                            begin
                                state_reg <= S_LINKW;
                            end
                            else
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                        else if (!nb_reg[n_slot].vis)
                        begin
                            carve_reg    <= 1'b1;
                            wr2_en_reg   <= c2_en;
                            wr1_addr_reg <= c1_addr;
                            wr1_data_reg <= c1_data;
                            wr2_addr_reg <= c2_addr;
                            wr2_data_reg <= c2_data;
                            kind_reg     <= KIND_CARVE;
                            done_reg     <= 1'b0;
                            state_reg    <= S_WR1;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_LINKW:
                begin
                    cur_x_reg  <= link_rdata[XW-1:0];
                    cur_y_reg  <= link_rdata[LW-1:XW];
                    bt_cnt_reg <= bt_cnt_reg + BW'(1);
                    rd_k_reg   <= '0;
                    state_reg  <= S_RD;
                end
                S_WR1, S_WR2:
                begin
                    if (state_reg == S_WR1 && wr2_en_reg)
                    begin
                        state_reg <= S_WR2;
                    end
                    else if (carve_reg)
                    begin
                        cur_x_reg <= n_x_reg;
                        cur_y_reg <= n_y_reg;
                        cnt_reg   <= cnt_inc;
                        if (cnt_inc >= CW'(TOTAL))
                        begin
                            post_carve_reg <= 1'b1;
                            rd_k_reg       <= '0;
                            state_reg      <= S_RD;
                        end
                        else
                        begin
                            phase_reg <= PH_CHECK;
                            state_reg <= S_EMIT;
                        end
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= 4'(wx_reg);
                        out_y_reg     <= 4'(wy_reg);
                        out_side_reg  <= side_reg;
                        out_kind_reg  <= kind_reg;
                        out_done_reg  <= done_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign wall_cell_x  = out_x_reg;
    assign wall_cell_y  = out_y_reg;
    assign wall_side    = out_side_reg;
    assign opening_kind = out_kind_reg;
    assign maze_done    = out_done_reg;

endmodule
